### design/scb_pkg.sv
// shared types and constants for the sphere clip bounds pipeline
// no dependencies; imported by every design module but scb_checker
`default_nettype none

package scb_pkg;

	localparam int unsigned SqrtSteps = 32;
	localparam int unsigned QuoBits   = 15;
	localparam int unsigned ScaleW    = 24;
	localparam int unsigned NumW      = 120;
	localparam int unsigned DenW      = 97;

	localparam logic signed [15:0] OneQ14 = 16'sd16384;

	typedef enum logic [1:0] {
		REG_NEAR    = 2'd0,
		REG_SCALE_X = 2'd1,
		REG_SCALE_Y = 2'd2
	} cfg_reg_t;

	// per-axis values that ride alongside the square root
	typedef struct packed {
		logic        tag;
		logic        xneg;
		logic        zneg;
		logic        skip;
		logic [31:0] ax;
		logic [31:0] az;
		logic [30:0] r;
		logic [63:0] s;
		logic [62:0] p;
	} scb_side_t;

	// one tangent root entering the candidate pipeline
	typedef struct packed {
		logic        tag;
		logic        skip;
		logic        aneg;
		logic        xneg;
		logic        zneg;
		logic [63:0] amag;
		logic [31:0] ax;
		logic [31:0] az;
		logic [30:0] r;
		logic [63:0] s;
	} scb_root_in_t;

	// candidate bound leaving the candidate pipeline
	typedef struct packed {
		logic               tag;
		logic               hit;
		logic               aneg;
		logic signed [15:0] c;
	} scb_cand_t;

endpackage

`default_nettype wire

### design/scb_isqrt.sv
// pipelined floor square root of a 64-bit value, one result bit per stage
// uses scb_pkg (side-band struct and step count)
`default_nettype none

module scb_isqrt import scb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  logic [63:0] rad,
	input  scb_side_t   in_side,
	output logic        out_v,
	output logic [31:0] root,
	output scb_side_t   out_side
);

	logic [63:0] rem_s  [SqrtSteps];
	logic [63:0] res_s  [SqrtSteps];
	scb_side_t   side_s [SqrtSteps];
	logic        vld_s  [SqrtSteps];

	logic [63:0] prev_rem [SqrtSteps];
	logic [63:0] prev_res [SqrtSteps];
	scb_side_t   prev_side [SqrtSteps];
	logic        prev_v   [SqrtSteps];
	logic [63:0] trial    [SqrtSteps];
	logic [63:0] bitv     [SqrtSteps];
	logic [63:0] nrem     [SqrtSteps];
	logic [63:0] nres     [SqrtSteps];

	always_comb begin
		prev_rem[0]  = rad;
		prev_res[0]  = '0;
		prev_side[0] = in_side;
		prev_v[0]    = in_v;
		for (int i = 1; i < SqrtSteps; i++) begin
			prev_rem[i]  = rem_s[i-1];
			prev_res[i]  = res_s[i-1];
			prev_side[i] = side_s[i-1];
			prev_v[i]    = vld_s[i-1];
		end
		for (int i = 0; i < SqrtSteps; i++) begin
			bitv[i]  = 64'd1 << (2 * (SqrtSteps - 1 - i));
			trial[i] = prev_res[i] + bitv[i];
			if (prev_rem[i] >= trial[i]) begin
				nrem[i] = prev_rem[i] - trial[i];
				nres[i] = (prev_res[i] >> 1) + bitv[i];
			end else begin
				nrem[i] = prev_rem[i];
				nres[i] = prev_res[i] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SqrtSteps; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < SqrtSteps; i++) vld_s[i] <= prev_v[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < SqrtSteps; i++) begin
				rem_s[i]  <= nrem[i];
				res_s[i]  <= nres[i];
				side_s[i] <= prev_side[i];
			end
		end
	end

	assign out_v    = vld_s[SqrtSteps-1];
	assign root     = res_s[SqrtSteps-1][31:0];
	assign out_side = side_s[SqrtSteps-1];

endmodule

`default_nettype wire

### design/scb_root.sv
// candidate bound of one tangent root: wide products, then restoring divide
// uses scb_pkg (root and candidate structs, widths)
`default_nettype none

module scb_root import scb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  scb_root_in_t      rin,
	input  logic [ScaleW-1:0] scale,
	output logic              out_v,
	output scb_cand_t         cand
);

	typedef struct packed {
		logic tag;
		logic skip;
		logic aneg;
		logic xneg;
		logic zneg;
		logic qneg;
		logic nz;
		logic sat;
	} fl_t;

	fl_t         fl_in;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	fl_t         fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6;
	fl_t         fl_n3, fl_n6;
	logic [62:0] t1lo_s1, t1hi_s1;
	logic [63:0] t2lo_s1, t2hi_s1, dnlo_s1, dnhi_s1;
	logic [95:0] t1_s2, t2_s2, dnsum;
	logic [DenW-1:0] den_s2, den_s3, den_s4, den_s5, den_s6;
	logic [95:0] bm;
	logic        bn;
	logic [95:0] bmag_s3;
	logic [55:0] np0_s4, np1_s4, np2_s4;
	logic [NumW-1:0] num_s5, rem_s6;
	logic [NumW-1:0] satlim;

	logic [NumW-1:0]    rem_s [QuoBits];
	logic [QuoBits-1:0] quo_s [QuoBits];
	logic [DenW-1:0]    den_s [QuoBits];
	fl_t                fl_s  [QuoBits];
	logic               vld_s [QuoBits];

	logic [NumW-1:0]    prev_rem [QuoBits];
	logic [QuoBits-1:0] prev_quo [QuoBits];
	logic [DenW-1:0]    prev_den [QuoBits];
	fl_t                prev_fl  [QuoBits];
	logic               prev_v   [QuoBits];
	logic [NumW-1:0]    dsh      [QuoBits];
	logic [NumW-1:0]    nrem     [QuoBits];
	logic [QuoBits-1:0] nquo     [QuoBits];

	logic [QuoBits-1:0] k;
	fl_t                fl_f;
	logic               exact, up;
	logic [15:0]        kk;
	logic signed [16:0] cw;
	logic signed [15:0] cc;

	always_comb begin
		fl_in      = '0;
		fl_in.tag  = rin.tag;
		fl_in.skip = rin.skip;
		fl_in.aneg = rin.aneg;
		fl_in.xneg = rin.xneg;
		fl_in.zneg = rin.zneg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int i = 0; i < QuoBits; i++) vld_s[i] <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			for (int i = 0; i < QuoBits; i++) vld_s[i] <= prev_v[i];
			out_v <= vld_s[QuoBits-1];
		end
	end

	// partial products of r*s, a*x and z*a
	always_ff @(posedge clk) begin
		if (en) begin
			fl_s1   <= fl_in;
			t1lo_s1 <= rin.r * rin.s[31:0];
			t1hi_s1 <= rin.r * rin.s[63:32];
			t2lo_s1 <= rin.amag[31:0] * rin.ax;
			t2hi_s1 <= rin.amag[63:32] * rin.ax;
			dnlo_s1 <= rin.az * rin.amag[31:0];
			dnhi_s1 <= rin.az * rin.amag[63:32];
		end
	end

	assign dnsum = {dnhi_s1[63:0], 32'd0} + {32'd0, dnlo_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s2  <= fl_s1;
			t1_s2  <= {1'b0, t1hi_s1, 32'd0} + {33'd0, t1lo_s1};
			t2_s2  <= {t2hi_s1, 32'd0} + {32'd0, t2lo_s1};
			den_s2 <= {dnsum[94:0], 2'b00};
		end
	end

	// b = r*s - a*x as sign and magnitude
	always_comb begin
		if (fl_s2.aneg != fl_s2.xneg) begin
			bm = t1_s2 + t2_s2;
			bn = 1'b0;
		end else if (t1_s2 >= t2_s2) begin
			bm = t1_s2 - t2_s2;
			bn = 1'b0;
		end else begin
			bm = t2_s2 - t1_s2;
			bn = 1'b1;
		end
	end

	always_comb begin
		fl_n3      = fl_s2;
		fl_n3.qneg = (!bn) != (fl_s2.zneg != fl_s2.aneg);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s3   <= fl_n3;
			bmag_s3 <= bm;
			den_s3  <= den_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s4  <= fl_s3;
			den_s4 <= den_s3;
			np0_s4 <= bmag_s3[31:0] * scale;
			np1_s4 <= bmag_s3[63:32] * scale;
			np2_s4 <= bmag_s3[95:64] * scale;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s5  <= fl_s4;
			den_s5 <= den_s4;
			num_s5 <= {np2_s4, 64'd0} + {32'd0, np1_s4, 32'd0} + {64'd0, np0_s4};
		end
	end

	// den * 16385 marks a quotient past the clamp range
	assign satlim = {9'd0, den_s5, 14'd0} + {23'd0, den_s5};

	always_comb begin
		fl_n6     = fl_s5;
		fl_n6.nz  = num_s5 == '0;
		fl_n6.sat = satlim <= num_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s6  <= fl_n6;
			den_s6 <= den_s5;
			rem_s6 <= num_s5;
		end
	end

	// restoring divide, one quotient bit per stage, msb first
	always_comb begin
		prev_rem[0] = rem_s6;
		prev_quo[0] = '0;
		prev_den[0] = den_s6;
		prev_fl[0]  = fl_s6;
		prev_v[0]   = v_s6;
		for (int i = 1; i < QuoBits; i++) begin
			prev_rem[i] = rem_s[i-1];
			prev_quo[i] = quo_s[i-1];
			prev_den[i] = den_s[i-1];
			prev_fl[i]  = fl_s[i-1];
			prev_v[i]   = vld_s[i-1];
		end
		for (int i = 0; i < QuoBits; i++) begin
			dsh[i] = {{(NumW-DenW){1'b0}}, prev_den[i]} << (QuoBits - 1 - i);
			if (prev_rem[i] >= dsh[i]) begin
				nrem[i] = prev_rem[i] - dsh[i];
				nquo[i] = prev_quo[i] | ({{(QuoBits-1){1'b0}}, 1'b1} << (QuoBits - 1 - i));
			end else begin
				nrem[i] = prev_rem[i];
				nquo[i] = prev_quo[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QuoBits; i++) begin
				rem_s[i] <= nrem[i];
				quo_s[i] <= nquo[i];
				den_s[i] <= prev_den[i];
				fl_s[i]  <= prev_fl[i];
			end
		end
	end

	// directed rounding and clamp to [-1, 1]
	always_comb begin
		k     = quo_s[QuoBits-1];
		fl_f  = fl_s[QuoBits-1];
		exact = rem_s[QuoBits-1] == '0;
		up    = !exact && (fl_f.aneg ? fl_f.qneg : !fl_f.qneg);
		kk    = {1'b0, k} + {15'd0, up};
		cw    = fl_f.qneg ? -$signed({1'b0, kk}) : $signed({1'b0, kk});
		if (fl_f.nz) begin
			cc = '0;
		end else if (fl_f.sat) begin
			cc = fl_f.qneg ? -OneQ14 : OneQ14;
		end else if (cw > $signed({OneQ14[15], OneQ14})) begin
			cc = OneQ14;
		end else if (cw < -$signed({OneQ14[15], OneQ14})) begin
			cc = -OneQ14;
		end else begin
			cc = cw[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cand.tag  <= fl_f.tag;
			cand.hit  <= !fl_f.skip;
			cand.aneg <= fl_f.aneg;
			cand.c    <= cc;
		end
	end

endmodule

`default_nettype wire

### design/scb_axis.sv
// bounds of one screen axis: squares, square root, both tangent roots, merge
// uses scb_pkg, scb_isqrt and scb_root
`default_nettype none

module scb_axis import scb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic               tag,
	input  logic signed [31:0] x,
	input  logic signed [31:0] z,
	input  logic [30:0]        r,
	input  logic [ScaleW-1:0]  scale,
	output logic               out_v,
	output logic               out_tag,
	output logic signed [15:0] mn,
	output logic signed [15:0] mx
);

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        tag_s1, xneg_s1, zneg_s1;
	logic [31:0] ax_s1, az_s1;
	logic [30:0] r_s1;
	logic        tag_s2, xneg_s2, zneg_s2;
	logic [31:0] ax_s2, az_s2;
	logic [30:0] r_s2;
	logic [63:0] sqx_s2, sqz_s2;
	logic [61:0] r2_s2;
	logic [62:0] p_s2;
	logic [63:0] sum;
	scb_side_t   side_s3;
	logic [63:0] d_s3;
	logic        sq_v;
	logic [31:0] sq_root;
	scb_side_t   sq_side;
	scb_side_t   side_n;
	scb_side_t   side_s4;
	logic [63:0] t_s4;
	scb_root_in_t rin0_s5, rin1_s5;
	logic        rv0, rv1;
	scb_cand_t   c0, c1;
	logic signed [15:0] mn_c, mx_c;

	function automatic scb_root_in_t mk_root(input logic tn, input scb_side_t sd,
						 input logic [63:0] t);
		scb_root_in_t ri;
		logic [63:0]  pw;
		pw      = {1'b0, sd.p};
		ri.tag  = sd.tag;
		ri.xneg = sd.xneg;
		ri.zneg = sd.zneg;
		ri.ax   = sd.ax;
		ri.az   = sd.az;
		ri.r    = sd.r;
		ri.s    = sd.s;
		if (sd.xneg == tn) begin
			ri.amag = pw + t;
			ri.aneg = sd.xneg;
		end else if (pw >= t) begin
			ri.amag = pw - t;
			ri.aneg = sd.xneg;
		end else begin
			ri.amag = t - pw;
			ri.aneg = tn;
		end
		// tangent point must sit in front of the eye
		ri.skip = sd.skip || (ri.amag == '0) ||
			  (tn ? (sd.zneg != ri.aneg) : (sd.zneg == ri.aneg));
		return ri;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= sq_v;
			v_s5  <= v_s4;
			out_v <= rv0 & rv1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= tag;
			xneg_s1 <= x[31];
			zneg_s1 <= z[31];
			ax_s1   <= x[31] ? (~x + 32'd1) : x;
			az_s1   <= z[31] ? (~z + 32'd1) : z;
			r_s1    <= r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2  <= tag_s1;
			xneg_s2 <= xneg_s1;
			zneg_s2 <= zneg_s1;
			ax_s2   <= ax_s1;
			az_s2   <= az_s1;
			r_s2    <= r_s1;
			sqx_s2  <= ax_s1 * ax_s1;
			sqz_s2  <= az_s1 * az_s1;
			r2_s2   <= r_s1 * r_s1;
			p_s2    <= r_s1 * ax_s1;
		end
	end

	assign sum = sqx_s2 + sqz_s2;

	// eye inside the sphere or on the axis keeps the full range
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.tag  <= tag_s2;
			side_s3.xneg <= xneg_s2;
			side_s3.zneg <= zneg_s2;
			side_s3.skip <= (az_s2 == '0) || (sum <= {2'b00, r2_s2});
			side_s3.ax   <= ax_s2;
			side_s3.az   <= az_s2;
			side_s3.r    <= r_s2;
			side_s3.s    <= sum;
			side_s3.p    <= p_s2;
			d_s3         <= sum - {2'b00, r2_s2};
		end
	end

	scb_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s3),
		.rad      (d_s3),
		.in_side  (side_s3),
		.out_v    (sq_v),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// a zero root leaves no usable tangent
	always_comb begin
		side_n      = sq_side;
		side_n.skip = sq_side.skip || (sq_root == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_n;
			t_s4    <= sq_side.az * sq_root;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rin0_s5 <= mk_root(1'b0, side_s4, t_s4);
			rin1_s5 <= mk_root(1'b1, side_s4, t_s4);
		end
	end

	scb_root u_root0 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s5),
		.rin    (rin0_s5),
		.scale  (scale),
		.out_v  (rv0),
		.cand   (c0)
	);

	scb_root u_root1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s5),
		.rin    (rin1_s5),
		.scale  (scale),
		.out_v  (rv1),
		.cand   (c1)
	);

	always_comb begin
		mn_c = -OneQ14;
		mx_c = OneQ14;
		if (c0.hit) begin
			if (c0.aneg) begin
				if (c0.c > mn_c) mn_c = c0.c;
			end else begin
				if (c0.c < mx_c) mx_c = c0.c;
			end
		end
		if (c1.hit) begin
			if (c1.aneg) begin
				if (c1.c > mn_c) mn_c = c1.c;
			end else begin
				if (c1.c < mx_c) mx_c = c1.c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_tag <= c0.tag & c1.tag;
			mn      <= mn_c;
			mx      <= mx_c;
		end
	end

endmodule

`default_nettype wire

### design/sphere_clip_bounds_unit.sv
// sphere clip bounds unit: clip-space rectangle of a view-space sphere
// takes one word per cycle while the output is not stalled; built around the
// 32-stage square root and the 15-stage quotient pipeline
// a stalled output freezes the whole pipeline; nothing is lost or repeated
// arst_n clears all valid bits and loads near 6554, scale_x and scale_y 65536
// uses scb_pkg and scb_axis
`default_nettype none

module sphere_clip_bounds_unit import scb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_wdata,
	// sphere words
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic [30:0]        sphere_radius,
	// rectangle words
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] clip_min_x,
	output logic signed [15:0] clip_min_y,
	output logic signed [15:0] clip_max_x,
	output logic signed [15:0] clip_max_y
);

	logic [30:0]       near_q;
	logic [ScaleW-1:0] scale_x_q, scale_y_q;
	logic              en;
	logic signed [33:0] gap;
	logic              live;
	logic              xv, yv, xtag, ytag;
	logic signed [15:0] mnx, mxx, mny, mxy;
	logic              out_v_q;
	logic signed [15:0] min_x_q, min_y_q, max_x_q, max_y_q;

	// configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q    <= 31'd6554;
			scale_x_q <= 24'd65536;
			scale_y_q <= 24'd65536;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NEAR:    near_q    <= cfg_wdata;
				REG_SCALE_X: scale_x_q <= cfg_wdata[ScaleW-1:0];
				REG_SCALE_Y: scale_y_q <= cfg_wdata[ScaleW-1:0];
				default: ;
			endcase
		end
	end

	// global advance: every stage moves unless a finished word is held
	assign en       = !out_v_q || out_ready;
	assign in_ready = en;

	// sphere reaches the near plane when cz - r + near <= 0
	assign gap  = $signed({{2{center_z[31]}}, center_z}) - $signed({3'b000, sphere_radius})
		      + $signed({3'b000, near_q});
	assign live = gap[33] || (gap == '0);

	// the two axes run side by side on identical pipelines
	scb_axis u_axis_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (in_valid),
		.tag     (live),
		.x       (center_x),
		.z       (center_z),
		.r       (sphere_radius),
		.scale   (scale_x_q),
		.out_v   (xv),
		.out_tag (xtag),
		.mn      (mnx),
		.mx      (mxx)
	);

	scb_axis u_axis_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (in_valid),
		.tag     (live),
		.x       (center_y),
		.z       (center_z),
		.r       (sphere_radius),
		.scale   (scale_y_q),
		.out_v   (yv),
		.out_tag (ytag),
		.mn      (mny),
		.mx      (mxy)
	);

	// output register; spheres past the near plane give the empty rectangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= xv & yv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (xtag && ytag) begin
				min_x_q <= mnx;
				min_y_q <= mny;
				max_x_q <= mxx;
				max_y_q <= mxy;
			end else begin
				min_x_q <= OneQ14;
				min_y_q <= OneQ14;
				max_x_q <= -OneQ14;
				max_y_q <= -OneQ14;
			end
		end
	end

	assign out_valid  = out_v_q;
	assign clip_min_x = min_x_q;
	assign clip_min_y = min_y_q;
	assign clip_max_x = max_x_q;
	assign clip_max_y = max_y_q;

endmodule

`default_nettype wire

### design/scb_checker.sv
// port-level checks for sphere_clip_bounds_unit, attached by bind
// depends only on the top-level ports
`default_nettype none

module scb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [1:0]         cfg_index,
	input logic [30:0]        cfg_wdata,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [31:0] center_x,
	input logic signed [31:0] center_y,
	input logic signed [31:0] center_z,
	input logic [30:0]        sphere_radius,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] clip_min_x,
	input logic signed [15:0] clip_min_y,
	input logic signed [15:0] clip_max_x,
	input logic signed [15:0] clip_max_y
);

	// a held output word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(clip_min_x) &&
		$stable(clip_min_y) && $stable(clip_max_x) && $stable(clip_max_y))
		else $error("output word changed while stalled");

	// an empty output stage never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// stall on the output propagates to the input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted during output stall");

	// bounds stay within clip space
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> clip_min_x >= -16'sd16384 && clip_min_x <= 16'sd16384 &&
		clip_max_x >= -16'sd16384 && clip_max_x <= 16'sd16384 &&
		clip_min_y >= -16'sd16384 && clip_min_y <= 16'sd16384 &&
		clip_max_y >= -16'sd16384 && clip_max_y <= 16'sd16384)
		else $error("bound outside clip range");

endmodule

bind sphere_clip_bounds_unit scb_checker u_scb_checker (.*);

`default_nettype wire

### bench/sphere_clip_bounds_checker.sv
// checker for the sphere clip bounds unit: predicts each rectangle word and compares it
// watches the config port and both valid/ready channels; depends on scb_pkg
`timescale 1ns / 1ps
`default_nettype none

module sphere_clip_bounds_checker import scb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic [30:0]        sphere_radius,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] clip_min_x,
	input  logic signed [15:0] clip_min_y,
	input  logic signed [15:0] clip_max_x,
	input  logic signed [15:0] clip_max_y,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic signed [15:0] min_x;
		logic signed [15:0] min_y;
		logic signed [15:0] max_x;
		logic signed [15:0] max_y;
	} rect_t;

	rect_t       rect_q[$];
	logic [63:0] near_q16, sx_q16, sy_q16;

	assign pending = rect_q.size();

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// narrow one axis by the two tangent planes through the eye
	function automatic void tighten_axis(input longint x, input longint z,
		input logic [63:0] r, input logic [63:0] sc, inout longint lo_b, inout longint hi_b);
		logic         xneg, zneg, tneg, aneg, bneg, qneg, exact;
		logic [127:0] ax, az, s, r2, q, p, t, amag, t1, t2, bmag, num, den, k;
		longint       c;
		xneg = x < 0;
		zneg = z < 0;
		ax = xneg ? -x : x;
		az = zneg ? -z : z;
		if (az == 0) return;
		s = ax * ax + az * az;
		r2 = r * r;
		if (s <= r2) return;
		q = floor_sqrt(64'(s - r2));
		if (q == 0) return;
		p = r * ax;
		t = az * q;
		for (int rt = 0; rt < 2; rt++) begin
			tneg = (rt == 1);
			if (xneg == tneg) begin
				amag = p + t; aneg = xneg;
			end else if (p >= t) begin
				amag = p - t; aneg = xneg;
			end else begin
				amag = t - p; aneg = tneg;
			end
			if (amag == 0) continue;
			// tangent point behind the eye
			if (rt == 0 ? (zneg == aneg) : (zneg != aneg)) continue;
			t1 = r * s;
			t2 = amag * ax;
			if (aneg != xneg) begin
				bmag = t1 + t2; bneg = 0;
			end else if (t1 >= t2) begin
				bmag = t1 - t2; bneg = 0;
			end else begin
				bmag = t2 - t1; bneg = 1;
			end
			num = bmag * sc;
			den = az * amag * 4;
			if (num == 0) begin
				c = 0;
			end else begin
				qneg = (!bneg) != (zneg != aneg);
				if (den * 16385 <= num) begin
					k = 16385;
				end else begin
					k = 0;
					for (int b = 14; b >= 0; b--)
						if (den * (k | (128'd1 << b)) <= num) k = k | (128'd1 << b);
				end
				exact = (den * k == num);
				if (aneg) c = qneg ? -longint'(k + !exact) : longint'(k);
				else c = qneg ? -longint'(k) : longint'(k + !exact);
			end
			if (c > 16384) c = 16384;
			if (c < -16384) c = -16384;
			if (aneg) begin
				if (c > lo_b) lo_b = c;
			end else begin
				if (c < hi_b) hi_b = c;
			end
		end
	endfunction

	function automatic rect_t sphere_rect(input longint cx, input longint cy,
		input longint cz, input longint r);
		longint mnx, mny, mxx, mxy;
		rect_t  res;
		mnx = 16384; mny = 16384; mxx = -16384; mxy = -16384;
		if (cz - r <= -longint'(near_q16)) begin
			mnx = -16384; mny = -16384; mxx = 16384; mxy = 16384;
			tighten_axis(cx, cz, r, sx_q16, mnx, mxx);
			tighten_axis(cy, cz, r, sy_q16, mny, mxy);
		end
		res.min_x = 16'(mnx); res.min_y = 16'(mny);
		res.max_x = 16'(mxx); res.max_y = 16'(mxy);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rect_t exp_r;
		if (!arst_n) begin
			near_q16 <= 64'd6554;
			sx_q16   <= 64'd65536;
			sy_q16   <= 64'd65536;
			errors   <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_NEAR:    near_q16 <= 64'(cfg_wdata);
					REG_SCALE_X: sx_q16 <= 64'(cfg_wdata[23:0]);
					REG_SCALE_Y: sy_q16 <= 64'(cfg_wdata[23:0]);
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				rect_q.push_back(sphere_rect(center_x, center_y, center_z, sphere_radius));
			if (out_valid && out_ready) begin
				if (rect_q.size() == 0) begin
					$error("rectangle word with nothing expected");
					errors <= errors + 1;
				end else begin
					exp_r = rect_q.pop_front();
					if (clip_min_x !== exp_r.min_x || clip_min_y !== exp_r.min_y ||
					    clip_max_x !== exp_r.max_x || clip_max_y !== exp_r.max_y)
						errors <= errors + 1;
					if (clip_min_x !== exp_r.min_x)
						$error("clip_min_x expected %0d got %0d", exp_r.min_x, clip_min_x);
					if (clip_min_y !== exp_r.min_y)
						$error("clip_min_y expected %0d got %0d", exp_r.min_y, clip_min_y);
					if (clip_max_x !== exp_r.max_x)
						$error("clip_max_x expected %0d got %0d", exp_r.max_x, clip_max_x);
					if (clip_max_y !== exp_r.max_y)
						$error("clip_max_y expected %0d got %0d", exp_r.max_y, clip_max_y);
				end
			end
		end
	end

endmodule

`default_nettype wire

### bench/sphere_clip_bounds_unit_tb.sv
// top of the sphere clip bounds testbench: clock, reset, stimulus and verdict
// depends on scb_pkg, sphere_clip_bounds_unit and sphere_clip_bounds_checker
`timescale 1ns / 1ps
`default_nettype none

module sphere_clip_bounds_unit_tb;
	import scb_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [1:0]         cfg_index = REG_NEAR;
	logic [30:0]        cfg_wdata = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic signed [31:0] center_x = 0, center_y = 0, center_z = 0;
	logic [30:0]        sphere_radius = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [15:0] clip_min_x, clip_min_y, clip_max_x, clip_max_y;
	int                 errors, pending;
	int                 spheres_sent = 0;
	bit                 long_stall_done = 0;

	// 10 ns clock
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	sphere_clip_bounds_unit dut (.*);

	sphere_clip_bounds_checker chk (.*);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random magnitude spread over all octaves, random sign
	function automatic logic signed [31:0] spread_val();
		logic signed [31:0] v;
		v = $urandom >> $urandom_range(0, 31);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic send_sphere(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input logic [30:0] r);
		in_valid      <= 1;
		center_x      <= x;
		center_y      <= y;
		center_z      <= z;
		sphere_radius <= r;
		do @(posedge clk); while (!in_ready);
		spheres_sent++;
	endtask

	// drop valid for a random gap after an accepted word
	task automatic sender_gap();
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [30:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// idle: all expected words back, then the pipeline depth on top
	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic random_sphere();
		int kind;
		logic [31:0] x, y, z;
		logic [30:0] r;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			// sphere ahead of the eye at a plausible scale
			x = spread_val();
			y = spread_val();
			z = -($urandom >> $urandom_range(1, 31));
			r = $urandom >> $urandom_range(1, 31);
		end else if (kind < 85) begin
			x = $urandom;
			y = $urandom;
			z = $urandom;
			r = $urandom;
		end else begin
			// eye near or inside the sphere, or centre on an axis
			x = $urandom_range(0, 1) ? 0 : spread_val();
			y = $urandom_range(0, 1) ? 0 : spread_val();
			z = $urandom_range(0, 2) == 0 ? 0 : spread_val();
			r = $urandom_range(0, 1) ? $urandom_range(0, 3) : ($urandom >> 1);
		end
		send_sphere(x, y, z, r);
	endtask

	// receiver: random stalls plus one long hold-off to back up the pipeline
	initial begin
		forever begin
			if (!long_stall_done && spheres_sent >= 300) begin
				long_stall_done = 1;
				out_ready <= 0;
				repeat (250) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 0;
				repeat (gap_len() + 1) @(posedge clk);
			end else begin
				out_ready <= 1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [30:0] near_set[5];
		logic [30:0] sx_set[5];
		logic [30:0] sy_set[5];
		near_set = '{31'd6554, 31'd0, 31'h7FFFFFFF, 31'd65536, 31'd1};
		sx_set   = '{31'd65536, 31'd0, 31'hFFFFFF, 31'd131072, 31'd1};
		sy_set   = '{31'd65536, 31'hFFFFFF, 31'd0, 31'd98304, 31'd40000};

		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed corners with reset settings
		send_sphere(0, 0, 0, 0);
		send_sphere(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF);
		send_sphere(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
		send_sphere(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF);
		send_sphere(0, 0, -32'sd655360, 31'd65536);           // centred ahead
		send_sphere(32'sd131072, -32'sd196608, -32'sd327680, 31'd65536);
		send_sphere(0, 0, 32'sd655360, 31'd65536);            // behind the near plane
		send_sphere(0, 0, -32'sd6554, 0);                      // just touching near plane
		send_sphere(0, 0, -32'sd6553, 0);
		send_sphere(32'sd65536, 32'sd65536, -32'sd65536, 31'd655360); // eye inside
		send_sphere(32'sd3, 0, -32'sd4, 31'd5);                // eye on the surface
		send_sphere(32'sd655360, 32'sd655360, 0, 31'd131072);  // centre level with eye
		send_sphere(32'sd1, -32'sd1, -32'sd1, 31'd1);
		send_sphere(-32'sd655360, 32'sd655360, -32'sd65536, 31'd65536);
		send_sphere(32'sd6553600, 32'sd0, -32'sd65536, 31'd6553600);
		send_sphere(32'sh7FFFFFFF, 0, -32'sd1, 31'd0);
		send_sphere(0, 32'sh80000000, 32'sh80000000, 31'h40000000);

		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			write_reg(REG_NEAR, near_set[ph]);
			write_reg(REG_SCALE_X, sx_set[ph]);
			write_reg(REG_SCALE_Y, sy_set[ph]);
			@(posedge clk);
			for (int i = 0; i < 168; i++) begin
				random_sphere();
				sender_gap();
			end
		end

		wait_drained();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// run limit far beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### sphere_clip_bounds_unit.f
design/scb_pkg.sv
design/scb_isqrt.sv
design/scb_root.sv
design/scb_axis.sv
design/sphere_clip_bounds_unit.sv
design/scb_checker.sv
bench/sphere_clip_bounds_checker.sv
bench/sphere_clip_bounds_unit_tb.sv
